/* src/bfu_pkg.sv */
// Package: shared types and constants of the bilateral filter unit.
package bfu_pkg;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_RANGE   = 2'd1;
    localparam logic [1:0] REQ_SPATIAL = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam int          CMP_W      = 14;
    localparam int          ROW_W      = 10;
    localparam logic [10:0] RESET_WIDTH  = 11'd640;
    localparam logic [10:0] RESET_HEIGHT = 11'd480;
    localparam logic [10:0] MAX_HEIGHT   = 11'd1024;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  pixel_value;
        logic [7:0]  weight_index;
        logic [15:0] weight_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] out_value;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [10:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINE,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

/* src/bfu_chan_if.sv */
// Interface: valid/ready channel with a typed payload.
interface bfu_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/bilateral_image_filter_unit.sv */
// Top level: bilateral image filter with line store, tap-cell chain, MAC and divider.
//
//  channel  dir  payload      transfer when
//  i_in     in   t_in_item    valid & ready
//  i_cfg    in   t_cfg_item   valid & ready (ready always high)
//  o_out    out  t_out_item   valid & ready
//
// Load items are taken in the idle state; a pixel without a result passes the line update
// and returns to idle. A pixel with a result rotates one tap per cycle through the cell
// chain into the multiply-accumulate, which then drains, followed by 8 divider steps, the
// done pulse and the output state; a zero weight sum or a saturated quotient skips the steps.
// Reset: synchronous, active low; frame size returns to 640 x 480.
// A stalled output holds the block in its output state; the result register is free again
// once its transfer completes.
module bilateral_image_filter_unit #(
    parameter int WINDOW_RADIUS = 2,
    parameter int MAX_WIDTH     = 1024,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bfu_chan_if.sink   i_in,
    bfu_chan_if.sink   i_cfg,
    bfu_chan_if.source o_out
);
    localparam int DIAM = 2 * WINDOW_RADIUS + 1;
    localparam int TAPS = DIAM * DIAM;
    localparam int HIST = 2 * WINDOW_RADIUS;
    localparam int WB   = WEIGHT_BITS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CNTW = $clog2(TAPS + 1);
    localparam int DENW = 2 * WB + $clog2(TAPS);
    localparam int NUMW = DENW + 8;
    localparam int CMPW = bfu_pkg::CMP_W;

    bfu_pkg::t_state r_state, n_state;

    logic [10:0]     r_fw, r_fh;
    logic [CW-1:0]   r_col;
    logic [9:0]      r_row;
    logic [7:0]      r_px;
    logic [CNTW-1:0] r_cnt;
    logic [7:0]      r_centre;
    logic            r_v1, r_v2, r_v3;
    logic [7:0]      r_p1, r_p2;
    logic [WB-1:0]   r_s1;
    logic [2*WB-1:0] r_w, r_w3;
    logic [2*WB+7:0] r_wp;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [9:0]      r_orow, r_ocol;
    logic            r_last;
    logic            r_ov;
    bfu_pkg::t_out_item r_out;

    logic            in_acc;
    logic [CMPW-1:0] w_eff, h_eff, col_p1, row_p1;
    logic            emit, last, row_end;
    logic [8*HIST-1:0] line_rd, line_wr;
    logic [7:0]      vec [DIAM];
    logic [WB-1:0]   wv;
    logic            issue, mac_end;
    logic [7:0]      head_px, centre_now, diff;
    logic [WB-1:0]   head_w, range_rd;
    logic            div_done;
    logic [7:0]      div_q;
    logic            out_free;

    logic [7:0]            cell_px [TAPS];
    logic [WB-1:0]         cell_w  [TAPS];
    bfu_pkg::t_cell_ctrl   cell_ctrl;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == bfu_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign wv = WB'(i_in.data.weight_value);

    // frame size clamp and position
    always_comb begin
        if (r_fw == 11'd0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_fw) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_fw);
        end
        if (r_fh == 11'd0) begin
            h_eff = CMPW'(1);
        end else if (r_fh > bfu_pkg::MAX_HEIGHT) begin
            h_eff = CMPW'(bfu_pkg::MAX_HEIGHT);
        end else begin
            h_eff = CMPW'(r_fh);
        end
    end

    assign col_p1  = CMPW'(r_col) + CMPW'(1);
    assign row_p1  = CMPW'(r_row) + CMPW'(1);
    assign row_end = col_p1 >= w_eff;
    assign last    = row_end && (row_p1 >= h_eff);
    assign emit    = (CMPW'(r_row) >= CMPW'(HIST)) && (CMPW'(r_col) >= CMPW'(HIST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= bfu_pkg::RESET_WIDTH;
            r_fh <= bfu_pkg::RESET_HEIGHT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.data.index == bfu_pkg::CFG_WIDTH) begin
                r_fw <= i_cfg.data.value;
            end else if (i_cfg.data.index == bfu_pkg::CFG_HEIGHT) begin
                r_fh <= i_cfg.data.value;
            end
        end
    end

    // line store: previous rows at each column in one word
    bfu_ram #(.WIDTH(8 * HIST), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (r_state == bfu_pkg::ST_LINE),
        .i_waddr (r_col),
        .i_wdata (line_wr),
        .i_re    (in_acc && i_in.data.req_type == bfu_pkg::REQ_PIXEL),
        .i_raddr (r_col),
        .o_rdata (line_rd)
    );

    always_comb begin
        for (int k = 0; k < HIST; k++) begin
            vec[k] = line_rd[8*k +: 8];
        end
        vec[HIST] = r_px;
        for (int k = 0; k < HIST; k++) begin
            line_wr[8*k +: 8] = vec[k+1];
        end
    end

    // tap cell chain
    assign cell_ctrl.shift  = (r_state == bfu_pkg::ST_LINE);
    assign cell_ctrl.rotate = issue;

    for (genvar t = 0; t < TAPS; t++) begin : g_cell
        localparam int TR = t / DIAM;
        localparam int TC = t % DIAM;
        logic [7:0] shift_src;
        if (TC == DIAM - 1) begin : g_edge
            assign shift_src = vec[TR];
        end else begin : g_mid
            assign shift_src = cell_px[t+1];
        end
        bfu_tap_cell #(.WB(WB)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_load_w   (in_acc && i_in.data.req_type == bfu_pkg::REQ_SPATIAL
                         && i_in.data.weight_index == 8'(t)),
            .i_load_val (wv),
            .i_shift_px (shift_src),
            .i_rot_px   (cell_px[(t+1) % TAPS]),
            .i_rot_w    (cell_w[(t+1) % TAPS]),
            .o_px       (cell_px[t]),
            .o_w        (cell_w[t])
        );
    end

    // range weights and multiply-accumulate pipeline
    assign issue      = (r_state == bfu_pkg::ST_MAC) && (r_cnt != CNTW'(TAPS));
    assign mac_end    = (r_state == bfu_pkg::ST_MAC) && (r_cnt == CNTW'(TAPS))
                        && !r_v1 && !r_v2 && !r_v3;
    assign head_px    = cell_px[0];
    assign head_w     = cell_w[0];
    assign centre_now = (r_cnt == '0) ? cell_px[WINDOW_RADIUS * DIAM + WINDOW_RADIUS]
                                      : r_centre;
    assign diff       = (head_px > centre_now) ? head_px - centre_now : centre_now - head_px;

    bfu_ram #(.WIDTH(WB), .DEPTH(256)) u_range (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_in.data.req_type == bfu_pkg::REQ_RANGE),
        .i_waddr (i_in.data.weight_index),
        .i_wdata (wv),
        .i_re    (issue),
        .i_raddr (diff),
        .o_rdata (range_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_state == bfu_pkg::ST_LINE) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && r_cnt == '0) begin
            r_centre <= centre_now;
        end
        r_p1 <= head_px;
        r_s1 <= head_w;
        r_w  <= range_rd * r_s1;
        r_p2 <= r_p1;
        r_wp <= r_w * r_p2;
        r_w3 <= r_w;
        if (r_state == bfu_pkg::ST_LINE) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_v3) begin
            r_num <= r_num + NUMW'(r_wp);
            r_den <= r_den + DENW'(r_w3);
        end
    end

    bfu_div #(.DENW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_end),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // pixel position and result bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == bfu_pkg::ST_LINE) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= last ? 10'd0 : r_row + 10'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px <= i_in.data.pixel_value;
        end
        if (r_state == bfu_pkg::ST_LINE) begin
            r_orow <= r_row - 10'(WINDOW_RADIUS);
            r_ocol <= 10'(r_col) - 10'(WINDOW_RADIUS);
            r_last <= last;
        end
    end

    // output register
    assign out_free = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == bfu_pkg::ST_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bfu_pkg::ST_OUT && out_free) begin
            r_out.out_row    <= r_orow;
            r_out.out_col    <= r_ocol;
            r_out.out_value  <= div_q;
            r_out.frame_last <= r_last;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfu_pkg::ST_IDLE: begin
                if (in_acc && i_in.data.req_type == bfu_pkg::REQ_PIXEL) begin
                    n_state = bfu_pkg::ST_LINE;
                end
            end
            bfu_pkg::ST_LINE: begin
                n_state = emit ? bfu_pkg::ST_MAC : bfu_pkg::ST_IDLE;
            end
            bfu_pkg::ST_MAC: begin
                if (mac_end) begin
                    n_state = bfu_pkg::ST_DIV;
                end
            end
            bfu_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = bfu_pkg::ST_OUT;
                end
            end
            bfu_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = bfu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfu_pkg::ST_IDLE;
            end
        endcase
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(TAPS))
        else $error("tap count beyond window");

    a_div_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_end |-> (!r_v1 && !r_v2 && !r_v3 && r_cnt == CNTW'(TAPS)))
        else $error("divider started with taps in flight");

    a_pixel_to_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.req_type == bfu_pkg::REQ_PIXEL) |=> r_state == bfu_pkg::ST_LINE)
        else $error("pixel transfer did not reach line update");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == bfu_pkg::ST_OUT))
        else $error("result raised outside output state");
endmodule

/* src/bfu_ram.sv */
// Generic simple dual-port RAM with registered read.
module bfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/bfu_tap_cell.sv */
// Window tap cell: one pixel and its spatial weight, shifting or rotating along the chain.
module bfu_tap_cell #(
    parameter int WB = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfu_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_load_w,
    input  logic [WB-1:0]      i_load_val,
    input  logic [7:0]         i_shift_px,
    input  logic [7:0]         i_rot_px,
    input  logic [WB-1:0]      i_rot_w,
    output logic [7:0]         o_px,
    output logic [WB-1:0]      o_w
);
    logic [7:0]    r_px;
    logic [WB-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
        end else if (i_ctrl.rotate) begin
            r_px <= i_rot_px;
        end else if (i_ctrl.shift) begin
            r_px <= i_shift_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rotate) begin
            r_w <= i_rot_w;
        end else if (i_load_w) begin
            r_w <= i_load_val;
        end
    end

    assign o_px = r_px;
    assign o_w  = r_w;
endmodule

/* src/bfu_div.sv */
// Divider: rounded, saturated 8-bit quotient, one bit per cycle.
module bfu_div #(
    parameter int DENW = 37
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DENW+7:0]   i_num,
    input  logic [DENW-1:0]   i_den,
    output logic              o_done,
    output logic [7:0]        o_q
);
    localparam int RW = DENW + 9;

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_step;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_dsh;
    logic [7:0]    r_q;
    logic [RW-1:0] x;
    logic [RW-1:0] den8;
    logic          ge;

    assign x    = RW'(i_num) + RW'(i_den >> 1);
    assign den8 = RW'({i_den, 8'd0});
    assign ge   = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0 || x >= den8) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_step == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= x;
            r_dsh  <= RW'({i_den, 7'd0});
            r_step <= 3'd7;
            r_q    <= (i_den == '0) ? 8'd0 : ((x >= den8) ? 8'd255 : 8'd0);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q    <= {r_q[6:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
